// ===== rtl/hck_pkg.sv =====
package hck_pkg;

  localparam int ChanWidth   = 8;
  localparam int HueWidth    = 9;
  localparam int SpreadWidth = 8;
  localparam int DiffWidth   = 9;
  localparam int ScaledWidth = 17;
  localparam int ProdWidth   = HueWidth + SpreadWidth;

  localparam int DegPerSector = 60;
  localparam int FullTurn     = 360;
  localparam int GreenBase    = 2 * DegPerSector;
  localparam int BlueBase     = 4 * DegPerSector;

  localparam logic [ChanWidth-1:0] AlphaOpaque = 8'hFF;
  localparam logic [ChanWidth-1:0] AlphaClear  = 8'h00;

  localparam logic [HueWidth-1:0] HueLowReset  = 9'd70;
  localparam logic [HueWidth-1:0] HueHighReset = 9'd160;

  localparam int CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] RegHueLow  = 1'b0;
  localparam logic [CfgIndexWidth-1:0] RegHueHigh = 1'b1;

  // which component holds the maximum
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [ChanWidth-1:0]        red;
    logic [ChanWidth-1:0]        green;
    logic [ChanWidth-1:0]        blue;
    logic [SpreadWidth-1:0]      spread;
    sector_t                     sector;
    logic signed [DiffWidth-1:0] diff;
  } hck_entry_t;

  typedef struct packed {
    logic [HueWidth-1:0] hue_low;
    logic [HueWidth-1:0] hue_high;
  } hck_cfg_t;

endpackage

// ===== rtl/hck_front.sv =====
module hck_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hck_pkg::ChanWidth-1:0] red_in,
  input  logic [hck_pkg::ChanWidth-1:0] green_in,
  input  logic [hck_pkg::ChanWidth-1:0] blue_in,
  output logic                       ent_valid,
  input  logic                       ent_ready,
  output hck_pkg::hck_entry_t        ent
);
  import hck_pkg::*;

  logic [ChanWidth-1:0] mx;
  logic [ChanWidth-1:0] mn;
  hck_entry_t           ent_next;

  // max and min of the three components
  always_comb begin
    mx = (red_in > green_in) ? red_in : green_in;
    if (blue_in > mx) mx = blue_in;
    mn = (red_in < green_in) ? red_in : green_in;
    if (blue_in < mn) mn = blue_in;
  end

  // red wins ties, then green, then blue
  always_comb begin
    ent_next.red    = red_in;
    ent_next.green  = green_in;
    ent_next.blue   = blue_in;
    ent_next.spread = mx - mn;
    if (red_in == mx) begin
      ent_next.sector = SECT_RED;
      ent_next.diff   = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
    end else if (green_in == mx) begin
      ent_next.sector = SECT_GREEN;
      ent_next.diff   = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
    end else begin
      ent_next.sector = SECT_BLUE;
      ent_next.diff   = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
    end
  end

  assign in_ready = !ent_valid || ent_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (in_ready) begin
      ent_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent <= ent_next;
    end
  end

endmodule

// ===== rtl/hck_fifo.sv =====
module hck_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  hck_pkg::hck_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output hck_pkg::hck_entry_t pop_data
);
  import hck_pkg::*;

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] Full    = CntWidth'(DEPTH);

  hck_entry_t          slots [DEPTH];
  logic [PtrWidth-1:0] head;
  logic [PtrWidth-1:0] tail;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != Full);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == LastPtr) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == LastPtr) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_data;
    end
  end

endmodule

// ===== rtl/hck_back.sv =====
module hck_back (
  input  logic                          clk,
  input  logic                          rst,
  input  hck_pkg::hck_cfg_t             cfg,
  input  logic                          ent_valid,
  output logic                          ent_ready,
  input  hck_pkg::hck_entry_t           ent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hck_pkg::ChanWidth-1:0] red_out,
  output logic [hck_pkg::ChanWidth-1:0] green_out,
  output logic [hck_pkg::ChanWidth-1:0] blue_out,
  output logic [hck_pkg::ChanWidth-1:0] alpha_out
);
  import hck_pkg::*;

  localparam int SumWidth = ScaledWidth + 1;

  // stage 1: scaled hue and both threshold products
  logic                    s1_valid;
  logic                    s1_ready;
  logic [ChanWidth-1:0]    s1_red;
  logic [ChanWidth-1:0]    s1_green;
  logic [ChanWidth-1:0]    s1_blue;
  logic [ScaledWidth-1:0]  s1_scaled;
  logic [ProdWidth-1:0]    s1_low_prod;
  logic [ProdWidth-1:0]    s1_high_prod;

  logic [ScaledWidth-1:0]  base;
  logic signed [SumWidth-1:0] offset;
  logic signed [SumWidth-1:0] sum;
  logic [ScaledWidth-1:0]  scaled_next;
  logic                    out_load;

  // hue times spread, never negative after the wrap on the red sector
  always_comb begin
    offset = SumWidth'(ent.diff) * SumWidth'(DegPerSector);
    case (ent.sector)
      SECT_RED: begin
        base = ent.diff[DiffWidth-1] ?
               ScaledWidth'(ent.spread) * ScaledWidth'(FullTurn) : '0;
      end
      SECT_GREEN: base = ScaledWidth'(ent.spread) * ScaledWidth'(GreenBase);
      SECT_BLUE:  base = ScaledWidth'(ent.spread) * ScaledWidth'(BlueBase);
      default:    base = '0;
    endcase
    sum         = $signed({1'b0, base}) + offset;
    scaled_next = sum[ScaledWidth-1:0];
  end

  assign out_load  = !out_valid || out_ready;
  assign s1_ready  = !s1_valid || out_load;
  assign ent_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= ent_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_valid && s1_ready) begin
      s1_red       <= ent.red;
      s1_green     <= ent.green;
      s1_blue      <= ent.blue;
      s1_scaled    <= scaled_next;
      s1_low_prod  <= ProdWidth'(cfg.hue_low) * ProdWidth'(ent.spread);
      s1_high_prod <= ProdWidth'(cfg.hue_high) * ProdWidth'(ent.spread);
    end
  end

  // stage 2: strict compares into the output register
  always_ff @(posedge clk) begin
    if (s1_valid && out_load) begin
      red_out   <= s1_red;
      green_out <= s1_green;
      blue_out  <= s1_blue;
      alpha_out <= (ProdWidth'(s1_scaled) > s1_low_prod &&
                    ProdWidth'(s1_scaled) < s1_high_prod) ? AlphaClear : AlphaOpaque;
    end
  end

endmodule

// ===== rtl/hue_chroma_key_mask_top.sv =====
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[23:0] = red_in, green_in, blue_in
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata[31:0] = red, green, blue, alpha
// cfg       | in  | cfg_we (no wait)             | cfg_index, cfg_data[8:0]
//
// one pixel per clock while m_axis accepts; the front register loads on the input transfer edge,
// then the pixel passes through the queue slot, the product stage and the compare/output register,
// each registered, before output valid rises
// rst is synchronous: clears all valid flags and loads hue_low 70, hue_high 160
// the queue lets the front keep taking pixels while m_axis stalls, until it fills
module hue_chroma_key_mask_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out (low to high)
  input  logic                              cfg_we,
  input  logic [hck_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [hck_pkg::HueWidth-1:0]      cfg_data
);
  import hck_pkg::*;

  hck_cfg_t   cfg;
  hck_entry_t front_ent;
  hck_entry_t back_ent;
  logic       front_valid;
  logic       front_ready;
  logic       back_valid;
  logic       back_ready;

  // threshold registers, to be written only while the pipeline is empty; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_low  <= HueLowReset;
      cfg.hue_high <= HueHighReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegHueLow:  cfg.hue_low  <= cfg_data;
        RegHueHigh: cfg.hue_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: max/min, spread and sector of each pixel
  hck_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .red_in    (s_axis_tdata[7:0]),
    .green_in  (s_axis_tdata[15:8]),
    .blue_in   (s_axis_tdata[23:16]),
    .ent_valid (front_valid),
    .ent_ready (front_ready),
    .ent       (front_ent)
  );

  // short queue between classification and keying
  hck_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_ent),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_ent)
  );

  // back: exact cross-multiplied compare against both thresholds
  hck_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ent_valid (back_valid),
    .ent_ready (back_ready),
    .ent       (back_ent),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .red_out   (m_axis_tdata[7:0]),
    .green_out (m_axis_tdata[15:8]),
    .blue_out  (m_axis_tdata[23:16]),
    .alpha_out (m_axis_tdata[31:24])
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hck_pkg::*;

  localparam int ClkHalf       = 4;
  localparam int ResetCycles   = 9;
  localparam int CycleLimit    = 300000;
  localparam int DrainCycles   = 12;
  localparam int PhaseCount    = 10;
  localparam int PixelsPerPhase = 185;
  localparam int ReportLimit   = 10;

  // one pixel as offered on the input stream
  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } pixel_t;

  // one keyed pixel, laid out as m_axis_tdata (red in the low byte)
  typedef struct packed {
    logic [ChanWidth-1:0] alpha;
    logic [ChanWidth-1:0] blue;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] red;
  } keyed_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // red_in [7:0], green_in [15:8], blue_in [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // red_out, green_out, blue_out, alpha_out (low to high)
  logic                     cfg_we    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = RegHueLow;
  logic [HueWidth-1:0]      cfg_data  = '0;

  hue_chroma_key_mask_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // local copy of the key range, only changed while the block is idle
  logic [HueWidth-1:0] key_lo = HueLowReset;
  logic [HueWidth-1:0] key_hi = HueHighReset;

  pixel_t    pixel_q[$];        // pixels waiting to be offered
  keyed_px_t keyed_expect_q[$]; // keyed pixels owed by the block

  // idle odds in percent per side, and the sender hold-off
  int unsigned src_idle_pct  = 10;
  int unsigned sink_idle_pct = 10;
  logic        feed_hold     = 1'b0;
  logic        px_taken      = 1'b0;

  int unsigned cycles       = 0;
  int unsigned errors       = 0;
  int unsigned pixels_taken = 0;
  int unsigned pixels_keyed = 0;
  int unsigned ranges_used  = 1;

  keyed_px_t want_px;
  keyed_px_t got_px;

  // alpha for one pixel under the current key range; the hue is kept
  // multiplied by the spread so both strict compares stay exact integers
  function automatic logic [ChanWidth-1:0] predict_alpha(input pixel_t px);
    int rv;
    int gv;
    int bv;
    int mx;
    int mn;
    int spread;
    int hue_x_spread;
    rv = px.red;
    gv = px.green;
    bv = px.blue;
    mx = (rv > gv) ? rv : gv;
    mx = (mx > bv) ? mx : bv;
    mn = (rv < gv) ? rv : gv;
    mn = (mn < bv) ? mn : bv;
    spread = mx - mn;
    // black and grey have hue zero, which no unsigned low bound lies under
    if (mx == 0 || spread == 0) return AlphaOpaque;
    // red wins ties, then green
    if (rv == mx) begin
      hue_x_spread = DegPerSector * (gv - bv);
      if (hue_x_spread < 0) hue_x_spread += FullTurn * spread;
    end else if (gv == mx) begin
      hue_x_spread = GreenBase * spread + DegPerSector * (bv - rv);
    end else begin
      hue_x_spread = BlueBase * spread + DegPerSector * (rv - gv);
    end
    if (int'(key_lo) * spread < hue_x_spread && hue_x_spread < int'(key_hi) * spread)
      return AlphaClear;
    return AlphaOpaque;
  endfunction

  function automatic pixel_t make_pixel(input int unsigned r, input int unsigned g,
                                        input int unsigned b);
    pixel_t px;
    px.red   = r[7:0];
    px.green = g[7:0];
    px.blue  = b[7:0];
    return px;
  endfunction

  // random pixel, weighted toward greys, ties and the ends of the range
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned top;
    int unsigned other;
    int unsigned mid;
    int unsigned mode;
    mode  = $urandom_range(9);
    top   = $urandom_range(255);
    other = $urandom_range(255);
    mid   = $urandom_range(255);
    case (mode)
      0: begin
        px = make_pixel(top, top, top);
      end
      1: begin
        // two components share the maximum
        case ($urandom_range(2))
          0:       px = make_pixel(top, top, other);
          1:       px = make_pixel(top, other, top);
          default: px = make_pixel(other, top, top);
        endcase
      end
      2: begin
        px = make_pixel($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1),
                        $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1),
                        $urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
      end
      3: begin
        // full spread, hue set by the middle component
        case ($urandom_range(5))
          0:       px = make_pixel(255, mid, 0);
          1:       px = make_pixel(255, 0, mid);
          2:       px = make_pixel(mid, 255, 0);
          3:       px = make_pixel(0, 255, mid);
          4:       px = make_pixel(mid, 0, 255);
          default: px = make_pixel(0, mid, 255);
        endcase
      end
      default: begin
        px = make_pixel(top, other, mid);
      end
    endcase
    return px;
  endfunction

  // sender and receiver: inputs move only on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      // a pixel on offer stays put until its transfer has happened
      if (!s_axis_tvalid || px_taken) begin
        if (pixel_q.size() != 0 && !feed_hold && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= {pixel_q[0].blue, pixel_q[0].green, pixel_q[0].red};
          s_axis_tvalid <= 1'b1;
          void'(pixel_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input keyed_px_t want,
                                 input keyed_px_t got);
    errors++;
    if (errors <= ReportLimit)
      $display("%s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
               what, want.red, want.green, want.blue, want.alpha,
               got.red, got.green, got.blue, got.alpha);
  endtask

  // both transfers are seen on the rising edge, before any register moves
  always @(posedge clk) begin
    if (rst) begin
      px_taken <= 1'b0;
    end else begin
      px_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        want_px.red   = s_axis_tdata[7:0];
        want_px.green = s_axis_tdata[15:8];
        want_px.blue  = s_axis_tdata[23:16];
        want_px.alpha = predict_alpha(make_pixel(want_px.red, want_px.green, want_px.blue));
        keyed_expect_q.push_back(want_px);
        pixels_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = m_axis_tdata;
        if (got_px.alpha == AlphaClear) pixels_keyed++;
        if (keyed_expect_q.size() == 0) begin
          report_mismatch("unexpected output transfer", '0, got_px);
        end else begin
          want_px = keyed_expect_q.pop_front();
          if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
              got_px.blue !== want_px.blue || got_px.alpha !== want_px.alpha)
            report_mismatch("output mismatch", want_px, got_px);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d keyed pixels still owed",
               cycles, keyed_expect_q.size());
      $display("hue_chroma_key_mask_top: mismatch");
      $finish;
    end
  end

  // wait until every queued pixel has gone in and every keyed pixel came out;
  // checked on the rising edge, where the sender's signals and queue are settled
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_q.size() != 0 || s_axis_tvalid || keyed_expect_q.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_key_range(input int unsigned lo, input int unsigned hi);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= RegHueLow;
    cfg_data  <= lo[HueWidth-1:0];
    @(negedge clk);
    cfg_index <= RegHueHigh;
    cfg_data  <= hi[HueWidth-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    key_lo = lo[HueWidth-1:0];
    key_hi = hi[HueWidth-1:0];
    ranges_used++;
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) pixel_q.push_back(random_pixel());
  endtask

  // extreme key ranges for the first random phases: widest, one degree wide,
  // just under a full turn, inverted, both at the top of the register, top third
  int unsigned lo_tab[6] = '{0, 0, 359, 360, 511, 240};
  int unsigned hi_tab[6] = '{511, 1, 360, 0, 511, 360};

  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned swap;

    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;

    // directed pixels under the reset key range 70..160
    pixel_q.push_back(make_pixel(0, 0, 0));       // black
    pixel_q.push_back(make_pixel(255, 255, 255)); // white
    pixel_q.push_back(make_pixel(128, 128, 128)); // grey
    pixel_q.push_back(make_pixel(255, 0, 0));     // pure red
    pixel_q.push_back(make_pixel(0, 255, 0));     // pure green, hue 120
    pixel_q.push_back(make_pixel(0, 0, 255));     // pure blue
    pixel_q.push_back(make_pixel(255, 255, 0));   // red and green tie
    pixel_q.push_back(make_pixel(0, 255, 255));   // green and blue tie
    pixel_q.push_back(make_pixel(255, 0, 255));   // red and blue tie, wraps to 300
    pixel_q.push_back(make_pixel(255, 0, 1));     // wraps to just under 360
    pixel_q.push_back(make_pixel(1, 0, 0));       // spread of one
    pixel_q.push_back(make_pixel(0, 1, 0));
    pixel_q.push_back(make_pixel(200, 240, 0));   // exactly on the low bound
    pixel_q.push_back(make_pixel(199, 240, 0));   // just above the low bound
    pixel_q.push_back(make_pixel(201, 240, 0));   // just below the low bound
    pixel_q.push_back(make_pixel(0, 255, 170));   // exactly on the high bound
    pixel_q.push_back(make_pixel(0, 255, 169));   // just below the high bound
    pixel_q.push_back(make_pixel(0, 255, 171));   // just above the high bound
    pixel_q.push_back(make_pixel(255, 254, 0));
    pixel_q.push_back(make_pixel(170, 85, 255));
    wait_idle();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase < 6) begin
        set_key_range(lo_tab[phase], hi_tab[phase]);
      end else begin
        lo = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(360);
        hi = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(360);
        // mostly an ordered range, now and then left inverted
        if (lo > hi && $urandom_range(3) != 0) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        set_key_range(lo, hi);
      end

      // one phase runs flat out on both sides, one with a sink that stalls more often
      src_idle_pct  = (phase == 3) ? 0 : 10;
      sink_idle_pct = (phase == 3) ? 0 : (phase == 7) ? 40 : 10;

      queue_random(PixelsPerPhase / 2);
      do @(negedge clk); while (pixel_q.size() != 0);
      // hold the sender until the block has handed back everything it owes
      feed_hold = 1'b1;
      do @(negedge clk); while (s_axis_tvalid || keyed_expect_q.size() != 0);
      feed_hold = 1'b0;
      queue_random(PixelsPerPhase - PixelsPerPhase / 2);
      wait_idle();
    end

    errors += keyed_expect_q.size();
    $display("checked %0d pixels across %0d key ranges, %0d of them keyed out",
             pixels_taken, ranges_used, pixels_keyed);
    $display("included greys, tied maxima, wrap-around hues, exact bounds, inverted ranges");
    if (errors == 0) begin
      $display("hue_chroma_key_mask_top: match");
    end else begin
      $display("%0d failures", errors);
      $display("hue_chroma_key_mask_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hck_pkg.sv
rtl/hck_front.sv
rtl/hck_fifo.sv
rtl/hck_back.sv
rtl/hue_chroma_key_mask_top.sv
dv/tb.sv
